@@ rtl/core/stda_pkg.sv @@
// stda_pkg: shared constants and character helpers for the decimal report unit
// no dependencies; referenced by stda_accum and stda_bcd, imported by the top level
package stda_pkg;

  localparam int TotalBitsDefault = 32;
  localparam int MaxLine          = 22;
  localparam int ErrLen           = 14;
  localparam int ErrIdxW          = 4;

  localparam logic [ErrIdxW-1:0] ErrLast = ErrIdxW'(ErrLen - 1);

  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharComma    = 8'h2C;
  localparam logic [7:0] CharCr       = 8'h0D;
  localparam logic [7:0] CharLf       = 8'h0A;
  localparam logic [7:0] CharHexAlpha = 8'h37;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharColon    = 8'h3A;
  localparam logic [7:0] CharUpR      = 8'h52;
  localparam logic [7:0] CharUpX      = 8'h58;
  localparam logic [7:0] CharUpE      = 8'h45;
  localparam logic [7:0] CharLoR      = 8'h72;
  localparam logic [7:0] CharLoO      = 8'h6F;

  // decimal digits needed for an unsigned value of the given width
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? CharZero : CharHexAlpha;
    return base + {4'b0000, nib};
  endfunction

  // character of the receive error line at a given position
  function automatic logic [7:0] err_char(input logic [ErrIdxW-1:0] idx,
                                          input logic [7:0] status);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CharUpR;
      4'd1:    c = CharUpX;
      4'd2:    c = CharSpace;
      4'd3:    c = CharUpE;
      4'd4:    c = CharLoR;
      4'd5:    c = CharLoR;
      4'd6:    c = CharLoO;
      4'd7:    c = CharLoR;
      4'd8:    c = CharColon;
      4'd9:    c = CharSpace;
      4'd10:   c = hex_char(status[7:4]);
      4'd11:   c = hex_char(status[3:0]);
      4'd12:   c = CharCr;
      default: c = CharLf;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/stda_accum.sv @@
// stda_accum: running total with sequence tracking (next adds, repeat replaces, gap holds)
// depends on stda_pkg for the default total width
module stda_accum #(
  parameter int TotalBits = stda_pkg::TotalBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  logic [7:0]           seq,
  input  logic [15:0]          reading,
  output logic [TotalBits-1:0] total
);

  logic [7:0]           prev_seq;
  logic [15:0]          prev_reading;
  logic [16:0]          delta;
  logic [TotalBits-1:0] total_next;

  assign delta = {1'b0, reading} - {1'b0, prev_reading};

  always_comb begin
    priority if (seq == prev_seq + 8'd1) begin
      total_next = total + TotalBits'(reading);
    end else if (seq == prev_seq) begin
      total_next = total + TotalBits'($signed(delta));
    end else begin
      total_next = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      prev_seq     <= 8'hFF;
      prev_reading <= '0;
    end else if (upd) begin
      total        <= total_next;
      prev_seq     <= seq;
      prev_reading <= reading;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(total) && $stable(prev_seq) && $stable(prev_reading))
    else $error("accum state changed without an update");

  assert property (@(posedge clk) disable iff (rst)
    upd |=> prev_seq == $past(seq) && prev_reading == $past(reading))
    else $error("accum did not track the last sequence number");

  assert property (@(posedge clk) disable iff (rst)
    upd && seq == prev_seq + 8'd1 |=> total == $past(total) + TotalBits'($past(reading)))
    else $error("accum missed the next-sequence add");

  assert property (@(posedge clk) disable iff (rst)
    upd && seq != prev_seq && seq != prev_seq + 8'd1 |=> $stable(total))
    else $error("accum changed the total on a sequence gap");
`endif

endmodule

@@ rtl/core/stda_bcd.sv @@
// stda_bcd: bit-serial binary to decimal converter (shift and add-3, one bit a cycle)
// strips leading zero digits afterward; depends on stda_pkg for digit count
module stda_bcd #(
  parameter  int TotalBits = stda_pkg::TotalBitsDefault,
  localparam int Dig       = stda_pkg::dec_digits(TotalBits),
  localparam int NbW       = $clog2(TotalBits + 1),
  localparam int CntW      = $clog2(Dig + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TotalBits-1:0] value,
  input  logic [NbW-1:0]       nbits,
  output logic                 done,
  output logic [4*Dig-1:0]     bcd,
  output logic [CntW-1:0]      ndig
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SHIFT = 4'b0010,
    B_STRIP = 4'b0100,
    B_DONE  = 4'b1000
  } bphase_t;

  bphase_t              phase;
  logic [TotalBits-1:0] bin;
  logic [NbW-1:0]       bitcnt;
  logic [4*Dig-1:0]     adj;
  logic                 strip_more;

  always_comb begin
    for (int i = 0; i < Dig; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign strip_more = (ndig > CntW'(1)) && (bcd[4*Dig-1 -: 4] == 4'd0);
  assign done       = (phase == B_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= B_IDLE;
    end else begin
      unique case (phase)
        B_IDLE: begin
          if (start) phase <= B_SHIFT;
        end
        B_SHIFT: begin
          if (bitcnt == NbW'(1)) phase <= B_STRIP;
        end
        B_STRIP: begin
          if (!strip_more) phase <= B_DONE;
        end
        B_DONE: begin
          phase <= B_IDLE;
        end
        default: phase <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == B_IDLE && start) begin
      bin    <= value;
      bitcnt <= nbits;
      bcd    <= '0;
      ndig   <= CntW'(Dig);
    end else if (phase == B_SHIFT) begin
      bcd    <= {adj[4*Dig-2:0], bin[TotalBits-1]};
      bin    <= bin << 1;
      bitcnt <= bitcnt - NbW'(1);
    end else if (phase == B_STRIP && strip_more) begin
      bcd  <= bcd << 4;
      ndig <= ndig - CntW'(1);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    start |-> phase == B_IDLE)
    else $error("conversion started while busy");

  assert property (@(posedge clk) disable iff (rst)
    done |-> bcd[4*Dig-1 -: 4] != 4'd0 || ndig == CntW'(1))
    else $error("result not left aligned");

  assert property (@(posedge clk) disable iff (rst)
    phase == B_SHIFT |-> bitcnt != '0)
    else $error("bit count underflow");

  assert property (@(posedge clk) disable iff (rst)
    phase == B_STRIP |-> ndig != '0)
    else $error("digit count reached zero");
`endif

endmodule

@@ rtl/core/sequenced_total_to_decimal_ascii_unit.sv @@
// sequenced_total_to_decimal_ascii_unit: packet in, one ascii report line out
// uses stda_pkg, stda_accum (running total) and stda_bcd (serial decimal converter)
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: rx_status, seq_num, power_reading,
//                                             battery_level
//  m_axis    out  m_axis_tvalid/tready       tdata: out_char; tlast: last_char
//  cfg       in   cfg_we                     cfg_wdata: good_status
//
// good packet: the serial converter runs once each for sequence, total and battery
// error packet: one character a cycle unless the output stalls, from a fixed text with the status in hex
// synchronous reset clears the total, sequence tracking, good_status and the sequencer
// output stalls hold the line; the next request is taken once the final line feed
//   sits in the output register
module sequenced_total_to_decimal_ascii_unit #(
  parameter int TotalBits = stda_pkg::TotalBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // rx_status, seq_num, power_reading, battery_level
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_char
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  import stda_pkg::*;

  localparam int Dig  = dec_digits(TotalBits);
  localparam int NbW  = $clog2(TotalBits + 1);
  localparam int CntW = $clog2(Dig + 1);
  localparam int LenW = $clog2(3 * Dig + 5);
  localparam int Top  = 4 * Dig - 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    F_SEQ = 2'd0,
    F_TOT = 2'd1,
    F_BAT = 2'd2
  } field_t;

  typedef enum logic [2:0] {
    P_SEQ = 3'd0,
    P_C1  = 3'd1,
    P_TOT = 3'd2,
    P_C2  = 3'd3,
    P_BAT = 3'd4,
    P_CR  = 3'd5,
    P_LF  = 3'd6
  } piece_t;

  state_t               state;
  field_t               fsel;
  piece_t               piece;
  logic [7:0]           good_status;
  logic [7:0]           status_q;
  logic [7:0]           seq_q;
  logic [15:0]          bat_q;
  logic [ErrIdxW-1:0]   err_idx;
  logic [LenW-1:0]      skip_cnt;
  logic [LenW-1:0]      line_len;
  logic [LenW-1:0]      skip_next;
  logic [4*Dig-1:0]     seq_dig, tot_dig, bat_dig;
  logic [CntW-1:0]      seq_cnt, tot_cnt, bat_cnt;
  logic                 ob_valid;
  logic [7:0]           ob_data;
  logic                 ob_last;
  logic                 in_acc, good_in, upd;
  logic                 adv, step, out_load;
  logic [7:0]           ch;
  logic                 ch_last;
  logic [TotalBits-1:0] total;
  logic                 bcd_start, bcd_done;
  logic [TotalBits-1:0] bcd_value;
  logic [NbW-1:0]       bcd_nbits;
  logic [4*Dig-1:0]     bcd_res;
  logic [CntW-1:0]      bcd_ndig;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign good_in       = (s_axis_tdata[7:0] == good_status);
  assign upd           = in_acc && good_in;

  assign m_axis_tvalid = ob_valid;
  assign m_axis_tdata  = ob_data;
  assign m_axis_tlast  = ob_last;

  assign adv      = !ob_valid || m_axis_tready;
  assign step     = (state == S_EMIT) && ((skip_cnt != '0) || adv);
  assign out_load = ((state == S_EMIT) && (skip_cnt == '0) && adv) ||
                    ((state == S_ERR) && adv);

  stda_accum #(.TotalBits(TotalBits)) u_accum (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .seq     (s_axis_tdata[15:8]),
    .reading (s_axis_tdata[31:16]),
    .total   (total)
  );

  assign bcd_start = (state == S_START);

  always_comb begin
    unique case (fsel)
      F_SEQ: begin
        bcd_value = TotalBits'(seq_q) << (TotalBits - 8);
        bcd_nbits = NbW'(8);
      end
      F_TOT: begin
        bcd_value = total;
        bcd_nbits = NbW'(TotalBits);
      end
      default: begin
        bcd_value = TotalBits'(bat_q) << (TotalBits - 16);
        bcd_nbits = NbW'(16);
      end
    endcase
  end

  stda_bcd #(.TotalBits(TotalBits)) u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .value (bcd_value),
    .nbits (bcd_nbits),
    .done  (bcd_done),
    .bcd   (bcd_res),
    .ndig  (bcd_ndig)
  );

  // line length once the battery digits are known; leftmost chars beyond the limit drop
  assign line_len  = LenW'(seq_cnt) + LenW'(tot_cnt) + LenW'(bcd_ndig) + LenW'(4);
  assign skip_next = (line_len > LenW'(MaxLine)) ? line_len - LenW'(MaxLine) : '0;

  always_comb begin
    ch      = CharLf;
    ch_last = 1'b0;
    if (state == S_ERR) begin
      ch      = err_char(err_idx, status_q);
      ch_last = (err_idx == ErrLast);
    end else begin
      unique case (piece)
        P_SEQ:   ch = CharZero + {4'b0000, seq_dig[Top -: 4]};
        P_TOT:   ch = CharZero + {4'b0000, tot_dig[Top -: 4]};
        P_BAT:   ch = CharZero + {4'b0000, bat_dig[Top -: 4]};
        P_C1:    ch = CharComma;
        P_C2:    ch = CharComma;
        P_CR:    ch = CharCr;
        P_LF:    ch_last = 1'b1;
        default: ch = CharLf;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fsel        <= F_SEQ;
      piece       <= P_SEQ;
      skip_cnt    <= '0;
      err_idx     <= '0;
      ob_valid    <= 1'b0;
      good_status <= '0;
    end else begin
      if (cfg_we) good_status <= cfg_wdata;

      if (out_load) begin
        ob_valid <= 1'b1;
      end else if (m_axis_tready) begin
        ob_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (good_in) begin
              state <= S_START;
              fsel  <= F_SEQ;
            end else begin
              state   <= S_ERR;
              err_idx <= '0;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (bcd_done) begin
            unique case (fsel)
              F_SEQ: begin
                fsel  <= F_TOT;
                state <= S_START;
              end
              F_TOT: begin
                fsel  <= F_BAT;
                state <= S_START;
              end
              default: begin
                skip_cnt <= skip_next;
                piece    <= P_SEQ;
                state    <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (step) begin
            if (skip_cnt != '0) skip_cnt <= skip_cnt - LenW'(1);
            unique case (piece)
              P_SEQ:   if (seq_cnt == CntW'(1)) piece <= P_C1;
              P_C1:    piece <= P_TOT;
              P_TOT:   if (tot_cnt == CntW'(1)) piece <= P_C2;
              P_C2:    piece <= P_BAT;
              P_BAT:   if (bat_cnt == CntW'(1)) piece <= P_CR;
              P_CR:    piece <= P_LF;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ERR: begin
          if (adv) begin
            if (err_idx == ErrLast) begin
              state <= S_IDLE;
            end else begin
              err_idx <= err_idx + ErrIdxW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_q <= s_axis_tdata[7:0];
      seq_q    <= s_axis_tdata[15:8];
      bat_q    <= s_axis_tdata[47:32];
    end

    if (out_load) begin
      ob_data <= ch;
      ob_last <= ch_last;
    end

    if (state == S_WAIT && bcd_done) begin
      unique case (fsel)
        F_SEQ: begin
          seq_dig <= bcd_res;
          seq_cnt <= bcd_ndig;
        end
        F_TOT: begin
          tot_dig <= bcd_res;
          tot_cnt <= bcd_ndig;
        end
        default: begin
          bat_dig <= bcd_res;
          bat_cnt <= bcd_ndig;
        end
      endcase
    end else if (step) begin
      unique case (piece)
        P_SEQ: begin
          seq_dig <= seq_dig << 4;
          seq_cnt <= seq_cnt - CntW'(1);
        end
        P_TOT: begin
          tot_dig <= tot_dig << 4;
          tot_cnt <= tot_cnt - CntW'(1);
        end
        P_BAT: begin
          bat_dig <= bat_dig << 4;
          bat_cnt <= bat_cnt - CntW'(1);
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    in_acc && good_in |=> state == S_START && fsel == F_SEQ)
    else $error("good request did not start conversion");

  assert property (@(posedge clk) disable iff (rst)
    in_acc && !good_in |=> state == S_ERR && err_idx == '0)
    else $error("bad request did not start error line");

  assert property (@(posedge clk) disable iff (rst)
    out_load && ch_last |=> state == S_IDLE && m_axis_tvalid && m_axis_tlast)
    else $error("line end not followed by idle");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CharLf)
    else $error("tlast on a character other than line feed");

  assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && (piece == P_CR || piece == P_LF) |-> skip_cnt == '0)
    else $error("line end would be dropped");
`endif

endmodule
